// ----- rtl/mtbr_pkg.sv -----
`default_nettype none

package mtbr_pkg;

  // table geometry and seeding constants
  localparam int unsigned MT_STATE_WORDS  = 624;
  localparam int unsigned MT_TWIST_OFFSET = 397;
  localparam logic [31:0] MT_SEED_RESET   = 32'd4357;
  localparam logic [31:0] MT_SEED_MULT    = 32'd69069;

  // twist and tempering constants
  localparam logic [31:0] MT_TWIST_XOR = 32'h9908b0df;
  localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c5680;
  localparam logic [31:0] MT_TEMPER_C  = 32'hefc60000;

  localparam int unsigned MT_WORD_W = 32;

  // standard output tempering
  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mtbr_ram.sv -----
`default_nettype none

module mtbr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/mtbr_div.sv -----
`default_nettype none

module mtbr_div
  import mtbr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] num_sh;
  logic [31:0] den_r;
  logic [32:0] trial;
  logic [32:0] trial_sub;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem, num_sh[31]};
    trial_sub = trial - {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, remainder stays below den so it fits 32 bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
      den_r  <= den;
    end else if (busy) begin
      num_sh <= {num_sh[30:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem <= trial_sub[31:0];
      end else begin
        rem <= trial[31:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mersenne_twister_bounded_rng_top.sv -----
// Bounded MT19937 generator.
// s_tdata carries a 32-bit exclusive bound; each accepted word returns one
// tempered twister word reduced modulo that bound on m_tdata (0 for bound 0).
// cfg_data on a cfg_valid/cfg_ready handshake sets the seed (reset 4357) and
// marks the table unseeded; cfg_ready is always high.
// The 624-word state sits in a single RAM with one write and one registered
// read port. A nonzero bound with the table ready goes through the RAM read,
// tempering and the 32-step restoring divider before m_tvalid; the sequencer
// returns to idle, ready for the next word, as the result is loaded.
// Bound zero goes straight to the done state and leaves the state alone.
// Every 624th word adds a table twist (two reads and one write per entry, the
// reads sharing the single read port); the first request after reset or after
// a seed write adds a fill of all 624 entries before that twist.
// Reset clears control only; no clearing pass runs. The result sits in an
// output register, so a stalled receiver does not block acceptance of the
// next bound; its result waits in the done state until the register frees.
`default_nettype none

module mersenne_twister_bounded_rng_top
  import mtbr_pkg::*;
#(
  parameter int unsigned STATE_WORDS  = MT_STATE_WORDS,
  parameter int unsigned TWIST_OFFSET = MT_TWIST_OFFSET
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] bound
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [31:0] value
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned AW    = $clog2(STATE_WORDS);
  localparam int unsigned IDX_W = $clog2(STATE_WORDS + 2);
  localparam logic [IDX_W-1:0] IDX_TWIST    = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(STATE_WORDS + 1);
  localparam logic [AW-1:0]    K_LAST       = AW'(STATE_WORDS - 1);
  localparam logic [AW:0]      SW_EXT       = (AW+1)'(STATE_WORDS);
  localparam logic [AW:0]      OFF_EXT      = (AW+1)'(TWIST_OFFSET);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_FILL    = 10'b00_0000_0010,
    ST_TW_HEAD = 10'b00_0000_0100,
    ST_TW_NXT  = 10'b00_0000_1000,
    ST_TW_FAR  = 10'b00_0001_0000,
    ST_TW_WR   = 10'b00_0010_0000,
    ST_GEN_RD  = 10'b00_0100_0000,
    ST_GEN_TMP = 10'b00_1000_0000,
    ST_DIV     = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  logic [31:0]      seed;
  logic [IDX_W-1:0] ridx;
  logic [AW-1:0]    k;
  logic [31:0]      bound_r;
  logic [31:0]      fill_word;
  logic [31:0]      lo_word;
  logic             hi_bit;
  logic [31:0]      res;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [31:0]      ram_rdata;

  logic             div_start;
  logic             div_done;
  logic [31:0]      div_rem;

  logic [AW-1:0]    k_nxt;
  logic [AW:0]      far_sum;
  logic [AW-1:0]    k_far;
  logic [31:0]      y_mix;
  logic [31:0]      twisted;
  logic             out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // neighbor indexes for the twist, wrapping at the table end
  always_comb begin
    k_nxt   = (k == K_LAST) ? '0 : k + AW'(1);
    far_sum = {1'b0, k} + OFF_EXT;
    if (far_sum >= SW_EXT) begin
      k_far = AW'(far_sum - SW_EXT);
    end else begin
      k_far = far_sum[AW-1:0];
    end
  end

  // twist of one entry: far word arrives on the read port in ST_TW_WR
  always_comb begin
    y_mix   = {hi_bit, lo_word[30:0]};
    twisted = ram_rdata ^ (y_mix >> 1) ^ (y_mix[0] ? MT_TWIST_XOR : '0);
  end

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k;
    ram_wdata = twisted;
    ram_raddr = ridx[AW-1:0];
    case (state)
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_word;
      end
      ST_TW_HEAD: ram_raddr = '0;
      ST_TW_NXT:  ram_raddr = k_nxt;
      ST_TW_FAR:  ram_raddr = k_far;
      ST_TW_WR:   ram_we = 1'b1;
      default: ;
    endcase
  end

  assign div_start = (state == ST_GEN_TMP);

  // sequencer transitions
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tdata == '0) begin
            state_next = ST_DONE;
          end else if (ridx == IDX_UNSEEDED) begin
            state_next = ST_FILL;
          end else if (ridx >= IDX_TWIST) begin
            state_next = ST_TW_HEAD;
          end else begin
            state_next = ST_GEN_RD;
          end
        end
      end
      ST_FILL:    if (k == K_LAST) state_next = ST_TW_HEAD;
      ST_TW_HEAD: state_next = ST_TW_NXT;
      ST_TW_NXT:  state_next = ST_TW_FAR;
      ST_TW_FAR:  state_next = ST_TW_WR;
      ST_TW_WR: begin
        state_next = (k == K_LAST) ? ST_GEN_RD : ST_TW_NXT;
      end
      ST_GEN_RD:  state_next = ST_GEN_TMP;
      ST_GEN_TMP: state_next = ST_DIV;
      ST_DIV:     if (div_done) state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seed     <= MT_SEED_RESET;
      ridx     <= IDX_UNSEEDED;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        seed <= cfg_data;
        ridx <= IDX_UNSEEDED;
      end else if (state == ST_TW_WR && k == K_LAST) begin
        ridx <= '0;
      end else if (state == ST_GEN_RD) begin
        ridx <= ridx + IDX_W'(1);
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        bound_r   <= s_tdata;
        fill_word <= seed;
        k         <= '0;
        res       <= '0;
      end
      ST_FILL: begin
        fill_word <= fill_word * MT_SEED_MULT;
        k         <= (k == K_LAST) ? '0 : k + AW'(1);
      end
      ST_TW_NXT: begin
        if (k == '0) begin
          hi_bit <= ram_rdata[31];
        end
      end
      ST_TW_FAR: lo_word <= ram_rdata;
      ST_TW_WR: begin
        hi_bit <= lo_word[31];
        k      <= k_nxt;
      end
      ST_DIV: begin
        if (div_done) begin
          res <= div_rem;
        end
      end
      default: ;
    endcase
    if (state == ST_DONE && out_free) begin
      m_tdata <= res;
    end
  end

  mtbr_ram #(
    .WIDTH (MT_WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mtbr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mt_temper(ram_rdata)),
    .den   (bound_r),
    .done  (div_done),
    .rem   (div_rem)
  );

  // read index never leaves its legal range
  a_ridx_range: assert property (@(posedge clk) disable iff (rst)
    ridx <= IDX_UNSEEDED)
    else $error("read index out of range");

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside divide state");

  // a new result is only loaded from the done state
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("output loaded outside done state");

  // loaded result respects the bound
  a_res_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |->
      ((bound_r == '0 && res == '0) || (bound_r != '0 && res < bound_r)))
    else $error("result not below bound");

endmodule

`default_nettype wire
